// ===== sv/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Round robin scheduler package
// Task states, request kinds, register indexes, reset values and the layout
// of the result beat shared by the scheduler and its checker.
// ----------------------------------------------------------------------------
package rrs_pkg;

   typedef enum logic [1:0] {
      ST_DEAD    = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_BLOCKED = 2'd3
   } task_state_type;

   typedef enum logic [2:0] {
      REQ_CREATE  = 3'd0,
      REQ_START   = 3'd1,
      REQ_TICK    = 3'd2,
      REQ_YIELD   = 3'd3,
      REQ_WAIT    = 3'd4,
      REQ_RELEASE = 3'd5
   } req_kind_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORK    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT    = 2'd2;

   localparam logic [15:0] QUANTUM_RESET    = 16'd333;
   localparam logic [15:0] WORK_RESET       = 16'd720;
   localparam logic [3:0]  INIT_COUNT_RESET = 4'd1;
   localparam logic [3:0]  SEM_MAX          = 4'd15;

   localparam int WAITQ_DEPTH = 8;
   localparam int WQ_PTR_W    = 3;
   localparam int WQ_CNT_W    = 4;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 24;

   // Bit positions of the result fields within rsp_tdata.
   localparam int RSP_SWITCHED  = 0;
   localparam int RSP_CUR_VALID = 1;
   localparam int RSP_CUR_TASK  = 2;
   localparam int RSP_GRANTED   = 5;
   localparam int RSP_BLOCKED   = 6;
   localparam int RSP_WOKE      = 7;
   localparam int RSP_WOKEN     = 8;
   localparam int RSP_OWN_VALID = 11;
   localparam int RSP_OWN_TASK  = 12;
   localparam int RSP_SEM_COUNT = 15;
   localparam int RSP_QDEPTH    = 19;

endpackage

// ===== sv/round_robin_scheduler_with_semaphore.sv =====
// ----------------------------------------------------------------------------
// Round robin scheduler with semaphore
// Task table in a single-port-read synchronous memory, a FIFO of semaphore
// waiters in a second memory, and a sequencer that reads, updates and
// writes back one task entry per cycle.
// ----------------------------------------------------------------------------
// Create, wait, unknown requests, ignored events and a release without a wake-up
// go from fetch straight to done. A start adds the write of the new running
// task, preceded by the old running task's step when another one runs; a release
// that wakes a waiter adds a wake step; tick visits every entry, a switch scans.
// One event is in flight at a time; a new request is taken only in idle.
// Reset is synchronous: tasks dead, no owner, queue empty, registers at reset.
module round_robin_scheduler_with_semaphore #(
   parameter int NUM_TASKS    = 8,
   parameter int ELAPSED_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // task_id[2:0], zero padding [7:3]
   input  logic [rrs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[2:0]
   input  logic [rrs_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // switched[0], current_valid[1], active_task[4:2], sem_granted[5],
   // task_blocked[6], woken_valid[7], woken_task[10:8], owner_valid[11],
   // owner_task[14:12], sem_count[18:15], queue_depth[22:19], zero [23]
   output logic [rrs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_wen,
   input  logic [rrs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rrs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int TID_W   = $clog2(NUM_TASKS);
   localparam int ENTRY_W = 2 + ELAPSED_BITS;
   localparam int SUM_W   = ((ELAPSED_BITS > 16) ? ELAPSED_BITS : 16) + 1;
   localparam logic [TID_W-1:0] LAST_TASK = TID_W'(NUM_TASKS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_START_OLD,
      S_START_NEW,
      S_SCAN,
      S_SWITCH,
      S_WAKE,
      S_TICK,
      S_DONE
   } seq_state_type;

   seq_state_type               state_ff, state_in;
   logic [2:0]                  req_ff, req_in;
   logic [TID_W-1:0]            tid_ff, tid_in;
   logic                        ok_ff, ok_in;
   rrs_pkg::task_state_type     ent_stat_ff, ent_stat_in;
   logic [ELAPSED_BITS-1:0]     ent_el_ff, ent_el_in;
   logic [TID_W-1:0]            idx_ff, idx_in;
   logic                        run_valid_ff, run_valid_in;
   logic [TID_W-1:0]            running_ff, running_in;
   logic [3:0]                  sem_count_ff, sem_count_in;
   logic                        owner_valid_ff, owner_valid_in;
   logic [TID_W-1:0]            owner_ff, owner_in;
   logic [rrs_pkg::WQ_PTR_W-1:0] head_ff, head_in;
   logic [rrs_pkg::WQ_PTR_W-1:0] tail_ff, tail_in;
   logic [rrs_pkg::WQ_CNT_W-1:0] count_ff, count_in;
   logic                        switched_ff, switched_in;
   logic                        granted_ff, granted_in;
   logic                        blocked_ff, blocked_in;
   logic                        woke_ff, woke_in;
   logic [TID_W-1:0]            woken_ff, woken_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rrs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [15:0]                 quantum_ff, quantum_in;
   logic [15:0]                 work_ff, work_in;
   logic [3:0]                  init_ff, init_in;

   logic [ENTRY_W-1:0]          task_mem [0:NUM_TASKS-1];
   logic [NUM_TASKS-1:0]        mem_valid_ff;
   logic [ENTRY_W-1:0]          rd_data_ff;
   logic                        rd_valid_ff;
   logic                        mem_we;
   logic [TID_W-1:0]            mem_wa;
   logic [TID_W-1:0]            mem_ra;
   rrs_pkg::task_state_type     mem_wstat;
   logic [ELAPSED_BITS-1:0]     mem_wel;

   logic [TID_W-1:0]            waitq_mem [0:rrs_pkg::WAITQ_DEPTH-1];
   logic [TID_W-1:0]            fifo_rd_ff;
   logic                        fifo_we;

   rrs_pkg::task_state_type     rd_status;
   logic [ELAPSED_BITS-1:0]     rd_elapsed;
   logic [SUM_W-1:0]            tick_sum;
   logic [ELAPSED_BITS-1:0]     tick_el;
   logic                        quantum_hit;
   logic                        live;
   logic                        req_ok;
   logic [TID_W-1:0]            req_tid;

   function automatic logic [TID_W-1:0] nxt_idx(input logic [TID_W-1:0] i);
      logic [TID_W-1:0] r;
      if (i == LAST_TASK) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

   assign rd_status  = rrs_pkg::task_state_type'(rd_valid_ff ?
                          rd_data_ff[ENTRY_W-1 -: 2] : rrs_pkg::ST_DEAD);
   assign rd_elapsed = rd_valid_ff ? rd_data_ff[ELAPSED_BITS-1:0] : '0;
   assign tick_sum   = SUM_W'(rd_elapsed) + SUM_W'(work_ff);
   assign tick_el    = (|tick_sum[SUM_W-1:ELAPSED_BITS]) ? '1 :
                       tick_sum[ELAPSED_BITS-1:0];
   assign quantum_hit = SUM_W'(rd_elapsed) >= SUM_W'(quantum_ff);
   assign live       = ok_ff && (rd_status != rrs_pkg::ST_DEAD);
   assign req_ok     = 32'(req_tdata[2:0]) < 32'(NUM_TASKS);
   assign req_tid    = TID_W'(req_tdata[2:0]);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      tid_in         = tid_ff;
      ok_in          = ok_ff;
      ent_stat_in    = ent_stat_ff;
      ent_el_in      = ent_el_ff;
      idx_in         = idx_ff;
      run_valid_in   = run_valid_ff;
      running_in     = running_ff;
      sem_count_in   = sem_count_ff;
      owner_valid_in = owner_valid_ff;
      owner_in       = owner_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      switched_in    = switched_ff;
      granted_in     = granted_ff;
      blocked_in     = blocked_ff;
      woke_in        = woke_ff;
      woken_in       = woken_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      quantum_in     = quantum_ff;
      work_in        = work_ff;
      init_in        = init_ff;
      mem_we         = 1'b0;
      mem_wa         = tid_ff;
      mem_wstat      = rrs_pkg::ST_DEAD;
      mem_wel        = '0;
      mem_ra         = idx_ff;
      fifo_we        = 1'b0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            mem_ra = req_ok ? req_tid : '0;
            if (req_tvalid) begin
               req_in      = req_tuser;
               tid_in      = req_tid;
               ok_in       = req_ok;
               switched_in = 1'b0;
               granted_in  = 1'b0;
               blocked_in  = 1'b0;
               woke_in     = 1'b0;
               woken_in    = '0;
               if (req_tuser == rrs_pkg::REQ_TICK) begin
                  mem_ra   = '0;
                  idx_in   = '0;
                  state_in = S_TICK;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            ent_stat_in = rd_status;
            ent_el_in   = rd_elapsed;
            state_in    = S_DONE;
            case (req_ff)
               rrs_pkg::REQ_CREATE: begin
                  if (ok_ff && rd_status == rrs_pkg::ST_DEAD) begin
                     mem_we    = 1'b1;
                     mem_wstat = rrs_pkg::ST_READY;
                  end
               end
               rrs_pkg::REQ_START: begin
                  if (ok_ff && rd_status == rrs_pkg::ST_READY) begin
                     if (run_valid_ff && running_ff != tid_ff) begin
                        mem_ra   = running_ff;
                        state_in = S_START_OLD;
                     end else begin
                        state_in = S_START_NEW;
                     end
                  end
               end
               rrs_pkg::REQ_YIELD: begin
                  if (live && quantum_hit) begin
                     idx_in   = nxt_idx(tid_ff);
                     mem_ra   = nxt_idx(tid_ff);
                     state_in = S_SCAN;
                  end
               end
               rrs_pkg::REQ_WAIT: begin
                  if (live) begin
                     if (sem_count_ff != 4'd0) begin
                        sem_count_in   = sem_count_ff - 4'd1;
                        owner_valid_in = 1'b1;
                        owner_in       = tid_ff;
                        granted_in     = 1'b1;
                     end else begin
                        mem_we     = 1'b1;
                        mem_wstat  = rrs_pkg::ST_BLOCKED;
                        blocked_in = 1'b1;
                        if (count_ff < rrs_pkg::WQ_CNT_W'(rrs_pkg::WAITQ_DEPTH)) begin
                           fifo_we  = 1'b1;
                           tail_in  = tail_ff + 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
               end
               rrs_pkg::REQ_RELEASE: begin
                  if (live && owner_valid_ff && owner_ff == tid_ff) begin
                     if (count_ff != '0) begin
                        head_in  = head_ff + 1'b1;
                        count_in = count_ff - 1'b1;
                        owner_in = fifo_rd_ff;
                        woke_in  = 1'b1;
                        woken_in = fifo_rd_ff;
                        mem_ra   = fifo_rd_ff;
                        state_in = S_WAKE;
                     end else begin
                        if (sem_count_ff != rrs_pkg::SEM_MAX) begin
                           sem_count_in = sem_count_ff + 4'd1;
                        end
                        owner_valid_in = 1'b0;
                        owner_in       = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_START_OLD: begin
            if (rd_status == rrs_pkg::ST_RUNNING) begin
               mem_we    = 1'b1;
               mem_wa    = running_ff;
               mem_wstat = rrs_pkg::ST_READY;
               mem_wel   = rd_elapsed;
            end
            state_in = S_START_NEW;
         end
         S_START_NEW: begin
            mem_we       = 1'b1;
            mem_wstat    = rrs_pkg::ST_RUNNING;
            mem_wel      = ent_el_ff;
            run_valid_in = 1'b1;
            running_in   = tid_ff;
            state_in     = S_DONE;
         end
         S_SCAN: begin
            if (rd_status == rrs_pkg::ST_READY || idx_ff == tid_ff) begin
               if (ent_stat_ff == rrs_pkg::ST_RUNNING && idx_ff != tid_ff) begin
                  mem_we    = 1'b1;
                  mem_wstat = rrs_pkg::ST_READY;
                  mem_wel   = ent_el_ff;
               end
               state_in = S_SWITCH;
            end else begin
               idx_in = nxt_idx(idx_ff);
               mem_ra = nxt_idx(idx_ff);
            end
         end
         S_SWITCH: begin
            mem_we       = 1'b1;
            mem_wa       = idx_ff;
            mem_wstat    = rrs_pkg::ST_RUNNING;
            run_valid_in = 1'b1;
            running_in   = idx_ff;
            switched_in  = 1'b1;
            state_in     = S_DONE;
         end
         S_WAKE: begin
            mem_we    = 1'b1;
            mem_wa    = woken_ff;
            mem_wstat = rrs_pkg::ST_READY;
            mem_wel   = rd_elapsed;
            state_in  = S_DONE;
         end
         S_TICK: begin
            if (rd_status != rrs_pkg::ST_DEAD) begin
               mem_we    = 1'b1;
               mem_wa    = idx_ff;
               mem_wstat = rd_status;
               mem_wel   = tick_el;
            end
            if (idx_ff == LAST_TASK) begin
               state_in = S_DONE;
            end else begin
               idx_in = nxt_idx(idx_ff);
               mem_ra = nxt_idx(idx_ff);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0,
                               count_ff,
                               sem_count_ff,
                               owner_valid_ff ? 3'(owner_ff) : 3'd0,
                               owner_valid_ff,
                               3'(woken_ff),
                               woke_ff,
                               blocked_ff,
                               granted_ff,
                               run_valid_ff ? 3'(running_ff) : 3'd0,
                               run_valid_ff,
                               switched_ff};
               state_in     = S_IDLE;
            end
         end
      endcase

      if (csr_wen) begin
         if (csr_index == rrs_pkg::CSR_QUANTUM) begin
            quantum_in = csr_wdata;
         end else if (csr_index == rrs_pkg::CSR_WORK) begin
            work_in = csr_wdata;
         end else if (csr_index == rrs_pkg::CSR_INIT) begin
            init_in      = csr_wdata[3:0];
            sem_count_in = csr_wdata[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         run_valid_ff   <= 1'b0;
         running_ff     <= '0;
         sem_count_ff   <= rrs_pkg::INIT_COUNT_RESET;
         owner_valid_ff <= 1'b0;
         owner_ff       <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         quantum_ff     <= rrs_pkg::QUANTUM_RESET;
         work_ff        <= rrs_pkg::WORK_RESET;
         init_ff        <= rrs_pkg::INIT_COUNT_RESET;
      end else begin
         state_ff       <= state_in;
         run_valid_ff   <= run_valid_in;
         running_ff     <= running_in;
         sem_count_ff   <= sem_count_in;
         owner_valid_ff <= owner_valid_in;
         owner_ff       <= owner_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         quantum_ff     <= quantum_in;
         work_ff        <= work_in;
         init_ff        <= init_in;
      end
      req_ff      <= req_in;
      tid_ff      <= tid_in;
      ok_ff       <= ok_in;
      ent_stat_ff <= ent_stat_in;
      ent_el_ff   <= ent_el_in;
      idx_ff      <= idx_in;
      switched_ff <= switched_in;
      granted_ff  <= granted_in;
      blocked_ff  <= blocked_in;
      woke_ff     <= woke_in;
      woken_ff    <= woken_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_mem[mem_wa] <= {mem_wstat, mem_wel};
      end
      rd_data_ff <= task_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            mem_valid_ff[mem_wa] <= 1'b1;
         end
         rd_valid_ff <= mem_valid_ff[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         waitq_mem[tail_ff] <= tid_ff;
      end
      fifo_rd_ff <= waitq_mem[head_ff];
   end

endmodule

// ===== sv/rrs_checker.sv =====
// ----------------------------------------------------------------------------
// Round robin scheduler checker
// Port-level checks on the result beats, attached to the scheduler by bind.
// ----------------------------------------------------------------------------
module rrs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rrs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // At most one event outcome is reported in a beat.
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[rrs_pkg::RSP_SWITCHED],
                               rsp_tdata[rrs_pkg::RSP_GRANTED],
                               rsp_tdata[rrs_pkg::RSP_BLOCKED],
                               rsp_tdata[rrs_pkg::RSP_WOKE]}))
      else $error("more than one outcome flag in a result beat");

   // A grant leaves the semaphore owned.
   a_grant_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[rrs_pkg::RSP_GRANTED]
         |-> rsp_tdata[rrs_pkg::RSP_OWN_VALID])
      else $error("grant without an owner");

   // A woken waiter becomes the owner.
   a_wake_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[rrs_pkg::RSP_WOKE]
         |-> rsp_tdata[rrs_pkg::RSP_OWN_VALID] &&
             rsp_tdata[rrs_pkg::RSP_OWN_TASK +: 3] == rsp_tdata[rrs_pkg::RSP_WOKEN +: 3])
      else $error("woken task is not the owner");

   // The queue never reports more waiters than it can hold.
   a_qdepth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[rrs_pkg::RSP_QDEPTH +: 4]) <= rrs_pkg::WAITQ_DEPTH)
      else $error("queue depth out of range");

endmodule

bind round_robin_scheduler_with_semaphore rrs_checker u_rrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_round_robin_scheduler_with_semaphore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the round robin scheduler with semaphore
// Event beats are queued together with the status that a behavioural copy of
// the scheduler predicts for them. A clocked driver sends them with random
// gaps and a clocked monitor checks every result beat field by field. The run
// opens with directed events and continues with random phases under several
// register settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_round_robin_scheduler_with_semaphore;
   import rrs_pkg::*;

   localparam int NUM_TASKS    = 8;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_EVENTS = 180;
   localparam bit [2:0] REQ_UNKNOWN_LO = 3'd6;
   localparam bit [2:0] REQ_UNKNOWN_HI = 3'd7;

   typedef struct packed {
      bit [2:0] kind;
      bit [2:0] id;
   } sched_event_type;

   typedef struct packed {
      bit       switched;
      bit       cur_valid;
      bit [2:0] cur_task;
      bit       granted;
      bit       blocked;
      bit       woke;
      bit [2:0] woken;
      bit       own_valid;
      bit [2:0] own_task;
      bit [3:0] count;
      bit [3:0] depth;
   } sched_status_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   sched_event_type  event_queue[$];
   sched_status_type expected_status[$];
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               errors = 0;

   // Behavioural copy of the scheduler state.
   task_state_type task_st [NUM_TASKS];
   bit [15:0]      task_work [NUM_TASKS];
   bit             run_valid;
   bit [2:0]       run_task;
   bit [3:0]       sem_count;
   bit             own_valid;
   bit [2:0]       own_task;
   bit [2:0]       waiters [WAITQ_DEPTH];
   bit [2:0]       wq_head;
   bit [2:0]       wq_tail;
   int             wq_count;
   bit [15:0]      quantum;
   bit [15:0]      work;
   bit [3:0]       init_count;

   round_robin_scheduler_with_semaphore #(
      .NUM_TASKS   (NUM_TASKS),
      .ELAPSED_BITS(16)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic void reset_scheduler_model();
      int i;
      for (i = 0; i < NUM_TASKS; i++) begin
         task_st[i] = ST_DEAD;
         task_work[i] = '0;
      end
      quantum = QUANTUM_RESET;
      work = WORK_RESET;
      init_count = INIT_COUNT_RESET;
      run_valid = 1'b0;
      run_task = '0;
      sem_count = INIT_COUNT_RESET;
      own_valid = 1'b0;
      own_task = '0;
      wq_head = '0;
      wq_tail = '0;
      wq_count = 0;
   endfunction

   function automatic sched_status_type schedule_event(bit [2:0] kind, bit [2:0] id);
      sched_status_type r;
      bit [2:0]         n;
      bit [16:0]        sum;
      bit               live;
      int               i;
      r = '0;
      live = task_st[id] != ST_DEAD;
      case (kind)
         REQ_CREATE: begin
            if (!live) begin
               task_st[id] = ST_READY;
               task_work[id] = '0;
            end
         end
         REQ_START: begin
            if (task_st[id] == ST_READY) begin
               if (run_valid && run_task != id && task_st[run_task] == ST_RUNNING)
                  task_st[run_task] = ST_READY;
               task_st[id] = ST_RUNNING;
               run_valid = 1'b1;
               run_task = id;
            end
         end
         REQ_TICK: begin
            for (i = 0; i < NUM_TASKS; i++) begin
               if (task_st[i] != ST_DEAD) begin
                  sum = task_work[i] + work;
                  task_work[i] = sum[16] ? 16'hFFFF : sum[15:0];
               end
            end
         end
         REQ_YIELD: begin
            if (live && task_work[id] >= quantum) begin
               n = id + 3'd1;
               while (task_st[n] != ST_READY && n != id)
                  n = n + 3'd1;
               if (task_st[id] == ST_RUNNING)
                  task_st[id] = ST_READY;
               task_st[n] = ST_RUNNING;
               task_work[n] = '0;
               run_valid = 1'b1;
               run_task = n;
               r.switched = 1'b1;
            end
         end
         REQ_WAIT: begin
            if (live) begin
               if (sem_count > 0) begin
                  sem_count--;
                  own_valid = 1'b1;
                  own_task = id;
                  r.granted = 1'b1;
               end else begin
                  task_st[id] = ST_BLOCKED;
                  task_work[id] = '0;
                  r.blocked = 1'b1;
                  if (wq_count < WAITQ_DEPTH) begin
                     waiters[wq_tail] = id;
                     wq_tail++;
                     wq_count++;
                  end
               end
            end
         end
         REQ_RELEASE: begin
            if (live && own_valid && own_task == id) begin
               if (wq_count > 0) begin
                  n = waiters[wq_head];
                  wq_head++;
                  wq_count--;
                  own_task = n;
                  task_st[n] = ST_READY;
                  r.woke = 1'b1;
                  r.woken = n;
               end else begin
                  if (sem_count < SEM_MAX)
                     sem_count++;
                  own_valid = 1'b0;
                  own_task = '0;
               end
            end
         end
         default: begin
         end
      endcase
      r.cur_valid = run_valid;
      r.cur_task = run_valid ? run_task : 3'd0;
      r.own_valid = own_valid;
      r.own_task = own_valid ? own_task : 3'd0;
      r.count = sem_count;
      r.depth = wq_count[3:0];
      return r;
   endfunction

   task automatic queue_event(bit [2:0] kind, bit [2:0] id);
      event_queue.push_back('{kind: kind, id: id});
      expected_status.push_back(schedule_event(kind, id));
   endtask

   // Random events lean towards well-formed use: starting ready tasks,
   // yields by the current task and releases by the owner.
   task automatic random_event();
      int       roll;
      bit [2:0] id;
      bit [2:0] k;
      bit [2:0] kind;
      bit       found;
      roll = $urandom_range(99);
      id = 3'($urandom_range(7));
      found = 1'b0;
      if (roll < 4) begin
         kind = $urandom_range(1) ? REQ_UNKNOWN_HI : REQ_UNKNOWN_LO;
      end else if (roll < 16) begin
         kind = REQ_CREATE;
      end else if (roll < 28) begin
         kind = REQ_START;
         if ($urandom_range(9) < 7) begin
            k = id;
            repeat (NUM_TASKS) begin
               if (!found && task_st[k] == ST_READY) begin
                  id = k;
                  found = 1'b1;
               end
               k++;
            end
         end
      end else if (roll < 42) begin
         kind = REQ_TICK;
      end else if (roll < 64) begin
         kind = REQ_YIELD;
         if (run_valid && $urandom_range(9) < 6)
            id = run_task;
      end else if (roll < 82) begin
         kind = REQ_WAIT;
      end else begin
         kind = REQ_RELEASE;
         if (own_valid && $urandom_range(3) != 0)
            id = own_task;
      end
      queue_event(kind, id);
   endtask

   task automatic wait_until_idle();
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, bit [15:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_QUANTUM: quantum = value;
         CSR_WORK:    work = value;
         CSR_INIT: begin
            init_count = value[3:0];
            sem_count = value[3:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic run_phase(bit [15:0] q, bit [15:0] w, bit [3:0] init,
                            int send_pct, int stall);
      wait_until_idle();
      write_register(CSR_QUANTUM, q);
      write_register(CSR_WORK, w);
      write_register(CSR_INIT, {12'd0, init});
      send_idle_pct = send_pct;
      stall_pct = stall;
      repeat (PHASE_EVENTS) random_event();
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin : drive_events
      sched_event_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = event_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {{(REQ_DATA_W-3){1'b0}}, beat.id};
            req_tuser <= beat.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_status
      sched_status_type want;
      logic [RSP_DATA_W-1:0] d;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            d = rsp_tdata;
            if (expected_status.size() == 0) begin
               $display("%0t ns: result beat %h arrived with nothing expected", $time, d);
               errors++;
            end else begin
               want = expected_status.pop_front();
               check_field("switched", 32'(want.switched), 32'(d[RSP_SWITCHED]));
               check_field("current_valid", 32'(want.cur_valid), 32'(d[RSP_CUR_VALID]));
               check_field("active_task", 32'(want.cur_task), 32'(d[RSP_CUR_TASK +: 3]));
               check_field("sem_granted", 32'(want.granted), 32'(d[RSP_GRANTED]));
               check_field("task_blocked", 32'(want.blocked), 32'(d[RSP_BLOCKED]));
               check_field("woken_valid", 32'(want.woke), 32'(d[RSP_WOKE]));
               check_field("woken_task", 32'(want.woken), 32'(d[RSP_WOKEN +: 3]));
               check_field("owner_valid", 32'(want.own_valid), 32'(d[RSP_OWN_VALID]));
               check_field("owner_task", 32'(want.own_task), 32'(d[RSP_OWN_TASK +: 3]));
               check_field("sem_count", 32'(want.count), 32'(d[RSP_SEM_COUNT +: 4]));
               check_field("queue_depth", 32'(want.depth), 32'(d[RSP_QDEPTH +: 4]));
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      reset_scheduler_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Dead tasks, unknown requests, scheduling and the semaphore hand-over.
      queue_event(REQ_UNKNOWN_LO, 3'd0);
      queue_event(REQ_UNKNOWN_HI, 3'd7);
      queue_event(REQ_YIELD, 3'd3);
      queue_event(REQ_RELEASE, 3'd2);
      queue_event(REQ_CREATE, 3'd0);
      queue_event(REQ_CREATE, 3'd7);
      queue_event(REQ_CREATE, 3'd0);
      queue_event(REQ_START, 3'd3);
      queue_event(REQ_START, 3'd0);
      queue_event(REQ_START, 3'd7);
      queue_event(REQ_YIELD, 3'd7);
      queue_event(REQ_TICK, 3'd5);
      queue_event(REQ_YIELD, 3'd0);
      queue_event(REQ_WAIT, 3'd0);
      queue_event(REQ_WAIT, 3'd7);
      queue_event(REQ_RELEASE, 3'd7);
      queue_event(REQ_RELEASE, 3'd0);
      queue_event(REQ_RELEASE, 3'd7);
      queue_event(REQ_WAIT, 3'd7);
      queue_event(REQ_WAIT, 3'd0);
      queue_event(REQ_TICK, 3'd0);
      queue_event(REQ_YIELD, 3'd0);
      queue_event(REQ_TICK, 3'd0);
      queue_event(REQ_YIELD, 3'd0);
      queue_event(REQ_RELEASE, 3'd7);
      queue_event(REQ_WAIT, 3'd3);

      run_phase(16'd0, 16'hFFFF, 4'd0, 0, 0);
      run_phase(16'hFFFF, 16'd0, 4'd15, 73, 0);
      run_phase(16'd1000, 16'd300, 4'd2, 0, 73);
      run_phase(16'($urandom_range(2000)), 16'($urandom_range(1000)),
                4'($urandom_range(15)), 20, 20);
      run_phase(QUANTUM_RESET, 16'($urandom), INIT_COUNT_RESET, 0, 0);
      wait_until_idle();

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rrs_pkg.sv
sv/round_robin_scheduler_with_semaphore.sv
sv/rrs_checker.sv
tb/tb_round_robin_scheduler_with_semaphore.sv
